[rtl/hgrl_pkg.sv]
// shared widths, limits and payload structs for the http get request line parser
// no dependencies; used by every module under rtl
`default_nettype none

package hgrl_pkg;

    localparam int BYTE_W  = 8;
    localparam int CLS_W   = 3;
    localparam int PORT_W  = 16;
    localparam int URL_MAX = 8192;
    localparam int CNT_W   = $clog2(URL_MAX + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              last_byte;
    } item_t;

    typedef struct packed {
        logic [CLS_W-1:0]  byte_class;
        logic              done_res;
        logic              bad_request;
        logic [PORT_W-1:0] port_number;
        logic              path_defaulted;
        logic [CNT_W-1:0]  url_length;
        logic [CNT_W-1:0]  host_length;
        logic [CNT_W-1:0]  path_length;
    } result_t;

endpackage

`default_nettype wire

[rtl/hgrl_in_reg.sv]
// input register stage of the request line parser
// holds one accepted byte until the core consumes it; uses hgrl_pkg
`default_nettype none

module hgrl_in_reg
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire hgrl_pkg::item_t in_item,
    input  wire logic           take,
    output logic                held_valid,
    output hgrl_pkg::item_t     held_item
);

    logic            valid_reg;
    logic            valid_next;
    hgrl_pkg::item_t item_reg;

    // free slot, or the held byte leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

[rtl/hgrl_core.sv]
// parse state and per-byte classification of the request line parser
// one byte is classified and the state updated per enabled cycle; uses hgrl_pkg
`default_nettype none

module hgrl_core
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire hgrl_pkg::item_t item,
    output hgrl_pkg::result_t    res
);

    localparam logic [3:0] PH_LEAD     = 4'd0;
    localparam logic [3:0] PH_METHOD   = 4'd1;
    localparam logic [3:0] PH_GAP      = 4'd2;
    localparam logic [3:0] PH_SCHEME   = 4'd3;
    localparam logic [3:0] PH_HOST     = 4'd4;
    localparam logic [3:0] PH_PORT_PRE = 4'd5;
    localparam logic [3:0] PH_PORT_NUM = 4'd6;
    localparam logic [3:0] PH_PATH     = 4'd7;
    localparam logic [3:0] PH_AFTER    = 4'd8;

    localparam logic [2:0] CLS_IGNORED = 3'd0;
    localparam logic [2:0] CLS_METHOD  = 3'd1;
    localparam logic [2:0] CLS_SCHEME  = 3'd2;
    localparam logic [2:0] CLS_HOST    = 3'd3;
    localparam logic [2:0] CLS_PORT    = 3'd4;
    localparam logic [2:0] CLS_PATH    = 3'd5;
    localparam logic [2:0] CLS_AFTER   = 3'd6;

    localparam int            CNT_W        = hgrl_pkg::CNT_W;
    localparam int            PORT_W       = hgrl_pkg::PORT_W;
    localparam logic [CNT_W-1:0] URL_LIMIT = CNT_W'(hgrl_pkg::URL_MAX);
    localparam logic [PORT_W-1:0] HTTP_PORT    = PORT_W'(80);
    localparam logic [PORT_W-1:0] PORT_SAT     = '1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    function automatic logic [7:0] method_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h47;
            2'd1:    ch = 8'h45;
            2'd2:    ch = 8'h54;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] scheme_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h68;
            3'd1:    ch = 8'h74;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h70;
            3'd4:    ch = 8'h3a;
            3'd5:    ch = 8'h2f;
            3'd6:    ch = 8'h2f;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    logic [3:0]        phase_reg,   phase_next;
    logic [2:0]        mi_reg,      mi_next;
    logic [PORT_W-1:0] accum_reg,   accum_next;
    logic              neg_reg,     neg_next;
    logic              pdone_reg,   pdone_next;
    logic              colon_reg,   colon_next;
    logic [CNT_W-1:0]  url_reg,     url_next;
    logic [CNT_W-1:0]  host_reg,    host_next;
    logic [CNT_W-1:0]  path_reg,    path_next;
    logic              err_reg,     err_next;
    logic              ended_reg,   ended_next;

    logic [7:0]        c;
    logic [2:0]        cls;
    logic [2:0]        smi;
    logic [19:0]       mul_sum;
    logic              bad;
    logic [PORT_W-1:0] port_val;

    assign c = item.byte_in;

    always_comb
    begin
        phase_next = phase_reg;
        mi_next    = mi_reg;
        accum_next = accum_reg;
        neg_next   = neg_reg;
        pdone_next = pdone_reg;
        colon_next = colon_reg;
        url_next   = url_reg;
        host_next  = host_reg;
        path_next  = path_reg;
        err_next   = err_reg;
        ended_next = ended_reg;
        cls        = CLS_IGNORED;
        smi        = (phase_reg == PH_GAP) ? 3'd0 : mi_reg;
        mul_sum    = {4'd0, accum_reg} * 20'd10 + {16'd0, c[3:0]};
        bad        = 1'b0;
        port_val   = '0;
        res        = '0;

        if (!(ended_reg || err_reg))
        begin
            if (c == 8'h00)
            begin
                if (phase_reg == PH_METHOD && mi_reg != 3'd3)
                begin
                    err_next = 1'b1;
                end
                ended_next = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_LEAD, PH_METHOD:
                    begin
                        if (c == CH_SPACE)
                        begin
                            if (phase_reg == PH_METHOD)
                            begin
                                if (mi_reg != 3'd3)
                                begin
                                    err_next = 1'b1;
                                end
                                phase_next = PH_GAP;
                                mi_next    = 3'd0;
                            end
                        end
                        else
                        begin
                            phase_next = PH_METHOD;
                            cls        = CLS_METHOD;
                            if (mi_reg < 3'd3 && c == method_char(mi_reg[1:0]))
                            begin
                                mi_next = mi_reg + 3'd1;
                            end
                            else
                            begin
                                err_next = 1'b1;
                            end
                        end
                    end
                    PH_GAP, PH_SCHEME:
                    begin
                        if (c == CH_SPACE)
                        begin
                            if (phase_reg == PH_SCHEME)
                            begin
                                err_next = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = PH_SCHEME;
                            mi_next    = smi;
                            cls        = CLS_SCHEME;
                            if (url_reg < URL_LIMIT)
                            begin
                                url_next = url_reg + 1'b1;
                            end
                            if (url_next >= URL_LIMIT)
                            begin
                                err_next = 1'b1;
                            end
                            if (smi < 3'd7 && c == scheme_char(smi))
                            begin
                                mi_next = smi + 3'd1;
                                if (smi == 3'd6)
                                begin
                                    phase_next = PH_HOST;
                                end
                            end
                            else
                            begin
                                err_next = 1'b1;
                            end
                        end
                    end
                    PH_HOST, PH_PORT_PRE, PH_PORT_NUM, PH_PATH:
                    begin
                        if (c == CH_SPACE)
                        begin
                            phase_next = PH_AFTER;
                            cls        = CLS_AFTER;
                        end
                        else
                        begin
                            if (url_reg < URL_LIMIT)
                            begin
                                url_next = url_reg + 1'b1;
                            end
                            if (url_next >= URL_LIMIT)
                            begin
                                err_next = 1'b1;
                            end
                            if (phase_reg == PH_PATH || c == CH_SLASH)
                            begin
                                phase_next = PH_PATH;
                                path_next  = path_reg + 1'b1;
                                cls        = CLS_PATH;
                            end
                            else if (phase_reg == PH_HOST)
                            begin
                                if (c == CH_COLON)
                                begin
                                    colon_next = 1'b1;
                                    phase_next = PH_PORT_PRE;
                                    cls        = CLS_PORT;
                                end
                                else
                                begin
                                    host_next = host_reg + 1'b1;
                                    cls       = CLS_HOST;
                                end
                            end
                            else
                            begin
                                cls = CLS_PORT;
                                if (!pdone_reg)
                                begin
                                    if (c >= CH_ZERO && c <= CH_NINE)
                                    begin
                                        // saturating decimal accumulate
                                        accum_next = (mul_sum > {4'd0, PORT_SAT}) ?
                                                     PORT_SAT : mul_sum[PORT_W-1:0];
                                        phase_next = PH_PORT_NUM;
                                    end
                                    else if (phase_reg == PH_PORT_PRE &&
                                             c >= CH_TAB && c <= CH_CR)
                                    begin
                                        phase_next = phase_reg;
                                    end
                                    else if (phase_reg == PH_PORT_PRE &&
                                             (c == CH_PLUS || c == CH_MINUS))
                                    begin
                                        neg_next   = (c == CH_MINUS);
                                        phase_next = PH_PORT_NUM;
                                    end
                                    else
                                    begin
                                        pdone_next = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    default:
                    begin
                        cls = CLS_AFTER;
                    end
                endcase
            end
        end

        res.byte_class = cls;

        if (item.last_byte)
        begin
            bad = err_next || (phase_next < PH_HOST) || (url_next >= URL_LIMIT);
            port_val = HTTP_PORT;
            if (colon_next)
            begin
                port_val = neg_next ? (PORT_W'(0) - accum_next) : accum_next;
            end
            res.done_res    = 1'b1;
            res.bad_request = bad;
            if (!bad)
            begin
                res.port_number    = port_val;
                res.path_defaulted = (path_next == '0);
                res.url_length     = url_next;
                res.host_length    = host_next;
                res.path_length    = path_next;
            end
            // back to the reset state for the next request
            phase_next = PH_LEAD;
            mi_next    = 3'd0;
            accum_next = '0;
            neg_next   = 1'b0;
            pdone_next = 1'b0;
            colon_next = 1'b0;
            url_next   = '0;
            host_next  = '0;
            path_next  = '0;
            err_next   = 1'b0;
            ended_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            mi_reg    <= 3'd0;
            accum_reg <= '0;
            neg_reg   <= 1'b0;
            pdone_reg <= 1'b0;
            colon_reg <= 1'b0;
            url_reg   <= '0;
            host_reg  <= '0;
            path_reg  <= '0;
            err_reg   <= 1'b0;
            ended_reg <= 1'b0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            mi_reg    <= mi_next;
            accum_reg <= accum_next;
            neg_reg   <= neg_next;
            pdone_reg <= pdone_next;
            colon_reg <= colon_next;
            url_reg   <= url_next;
            host_reg  <= host_next;
            path_reg  <= path_next;
            err_reg   <= err_next;
            ended_reg <= ended_next;
        end
    end

endmodule

`default_nettype wire

[rtl/http_get_request_line_parser.sv]
// Takes one request byte per transfer and returns one result per byte: the
// byte's field class, and on the byte marked last the status, port and
// lengths. A new byte can be taken every cycle while out_ready keeps the
// results draining; each byte passes through the input register, then the
// result register, where its result is held until it is taken, and the parse
// state is updated once per byte by combinational logic.
// After the last byte the parser returns to its reset state.
// top level of the request line parser; uses hgrl_pkg, hgrl_in_reg, hgrl_core
`default_nettype none

module http_get_request_line_parser
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [hgrl_pkg::BYTE_W-1:0]   byte_in,
    input  wire logic                          last_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [hgrl_pkg::CLS_W-1:0]         byte_class,
    output logic                               done_res,
    output logic                               bad_request,
    output logic [hgrl_pkg::PORT_W-1:0]        port_number,
    output logic                               path_defaulted,
    output logic [hgrl_pkg::CNT_W-1:0]         url_length,
    output logic [hgrl_pkg::CNT_W-1:0]         host_length,
    output logic [hgrl_pkg::CNT_W-1:0]         path_length
);

    hgrl_pkg::item_t   in_item;
    hgrl_pkg::item_t   held_item;
    hgrl_pkg::result_t core_res;
    hgrl_pkg::result_t res_reg;
    logic              held_valid;
    logic              take;
    logic              out_valid_reg;
    logic              out_valid_next;

    assign in_item.byte_in   = byte_in;
    assign in_item.last_byte = last_byte;

    // the held byte moves on when the result register is free or draining
    assign take = held_valid && (!out_valid_reg || out_ready);

    hgrl_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    hgrl_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (take),
        .item  (held_item),
        .res   (core_res)
    );

    assign out_valid_next = take || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= core_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign byte_class     = res_reg.byte_class;
    assign done_res       = res_reg.done_res;
    assign bad_request    = res_reg.bad_request;
    assign port_number    = res_reg.port_number;
    assign path_defaulted = res_reg.path_defaulted;
    assign url_length     = res_reg.url_length;
    assign host_length    = res_reg.host_length;
    assign path_length    = res_reg.path_length;

endmodule

`default_nettype wire
